// File: src/clr_pkg.sv
// Package for the clipped line rasteriser: coordinate widths, stream packing
// constants, the load/step opcode, register indexes and the item structs.
// Depends on nothing; every other file imports it.
package clr_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAME_BITS = 15;
  localparam int COLOR_BITS = 32;

  // Widths of the Bresenham state, derived from the coordinate width.
  localparam int DX_BITS  = COORD_BITS + 1;
  localparam int NDY_BITS = COORD_BITS + 2;
  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int E2_BITS  = COORD_BITS + 4;

  // Width used when comparing a non-negative coordinate with a frame size.
  localparam int CMP_BITS = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;

  // Stream payload widths, padded up to whole bytes.
  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int CFG_INDEX_BITS = 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0]        color_t;
  typedef logic [FRAME_BITS-1:0]        frame_dim_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t    op;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t color;
  } item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   write_enable;
    logic   last;
  } pixel_t;

  typedef struct packed {
    frame_dim_t width;
    frame_dim_t height;
  } frame_t;

endpackage

// File: src/clipped_line_rasterizer.sv
// Top level of the clipped line rasteriser: stream ports, payload packing and
// the configuration, input register and stepper instances.
// Depends on clr_pkg, clr_cfg, clr_in_reg and clr_stepper.
//
//   Channel   Direction  Carries
//   s_axis    in         load (tuser = 0) or step (tuser = 1) items
//   m_axis    out        one pixel per step of an active line
//   cfg       in         frame width (index 0) and height (index 1) writes
//
// Each item is held in the input register and its pixel is then written to the
// result register; one item is taken every cycle while m_axis does not stall.
// The Bresenham update (doubled error compares, a two-term add on the error word,
// the coordinate steps and the frame and end compares) lies between the two registers.
// Loads, and steps with no line active, drain from the input register even
// while a pixel waits on m_axis; only a step that produces a pixel waits.
// Reset clears the line-active flag and both valid flags, and sets the frame
// to 640 by 480. Configuration writes take effect the following cycle.
module clipped_line_rasterizer
  import clr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // Input stream.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // From bit 0: start_x, start_y, end_x, end_y, color.
  input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
  // op.
  input  logic                      s_axis_tuser,
  // Output stream.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // From bit 0: pixel_x, pixel_y, pixel_color.
  output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
  // write_enable.
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast,
  // Configuration writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FRAME_BITS-1:0]     cfg_data
);

  frame_t frame;
  item_t  in_item;
  item_t  item;
  logic   item_valid;
  logic   item_take;
  pixel_t res;

  // Unpack the input transfer; padding bits above the fields are ignored.
  always_comb begin
    in_item.op      = op_t'(s_axis_tuser);
    in_item.start_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    in_item.start_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    in_item.end_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    in_item.end_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    in_item.color   = s_axis_tdata[4*COORD_BITS +: COLOR_BITS];
  end

  clr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame)
  );

  clr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  clr_stepper u_stepper (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // Pack the pixel transfer, zero-filled up to a whole byte.
  assign m_axis_tdata = OUT_DATA_BITS'({res.pixel_color, res.pixel_y, res.pixel_x});
  assign m_axis_tuser = res.write_enable;
  assign m_axis_tlast = res.last;

endmodule

// File: src/clr_cfg.sv
// Frame size registers of the clipped line rasteriser, written through the
// configuration channel. Depends on clr_pkg.
module clr_cfg
  import clr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FRAME_BITS-1:0]     cfg_data,
  output frame_t                    frame
);

  localparam frame_dim_t WIDTH_RESET  = FRAME_BITS'(640);
  localparam frame_dim_t HEIGHT_RESET = FRAME_BITS'(480);

  // Writes go straight into the frame registers, so the channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.width  <= WIDTH_RESET;
      frame.height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame.width  <= cfg_data;
        REG_FRAME_HEIGHT: frame.height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/clr_in_reg.sv
// Input register of the clipped line rasteriser: holds one accepted item
// until the stepper takes it. Depends on clr_pkg.
module clr_in_reg
  import clr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  // A new item may enter whenever the register is empty or drains this cycle.
  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// File: src/clr_stepper.sv
// Bresenham stepper and result register of the clipped line rasteriser.
// Holds the line state, sets it up on load and advances it on each step of an active line.
// Depends on clr_pkg.
module clr_stepper
  import clr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  frame_t frame,
  input  logic   item_valid,
  input  item_t  item,
  output logic   item_take,
  output logic   res_valid,
  input  logic   res_ready,
  output pixel_t res
);

  // Line state.
  coord_t                     cur_x;
  coord_t                     cur_y;
  coord_t                     goal_x;
  coord_t                     goal_y;
  logic [DX_BITS-1:0]         delta_x;
  logic signed [NDY_BITS-1:0] neg_delta_y;
  logic signed [ERR_BITS-1:0] error_term;
  logic                       step_x_neg;
  logic                       step_y_neg;
  color_t                     line_color;
  logic                       active;

  // Set-up terms of a load.
  logic signed [DX_BITS-1:0]  load_dx;
  logic signed [DX_BITS-1:0]  load_dy;
  logic [DX_BITS-1:0]         load_abs_dx;
  logic signed [NDY_BITS-1:0] load_ndy;
  logic signed [ERR_BITS-1:0] load_err;

  // One Bresenham step.
  logic signed [E2_BITS-1:0]  e2;
  logic                       move_x;
  logic                       move_y;
  logic signed [ERR_BITS-1:0] error_term_next;
  coord_t                     cur_x_next;
  coord_t                     cur_y_next;
  logic                       in_frame;
  logic                       at_end;

  logic out_free;
  logic emits;

  always_comb begin
    load_dx     = DX_BITS'(item.end_x) - DX_BITS'(item.start_x);
    load_dy     = DX_BITS'(item.end_y) - DX_BITS'(item.start_y);
    load_abs_dx = load_dx[DX_BITS-1] ? DX_BITS'(-load_dx) : DX_BITS'(load_dx);
    load_ndy    = load_dy[DX_BITS-1] ? NDY_BITS'(load_dy) : -NDY_BITS'(load_dy);
    load_err    = ERR_BITS'(load_abs_dx) + ERR_BITS'(load_ndy);
  end

  always_comb begin
    e2     = E2_BITS'(error_term) <<< 1;
    move_x = e2 >= E2_BITS'(neg_delta_y);
    move_y = e2 <= $signed(E2_BITS'(delta_x));
    error_term_next = error_term
                    + (move_x ? ERR_BITS'(neg_delta_y) : '0)
                    + (move_y ? ERR_BITS'(delta_x) : '0);
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (move_x) begin
      cur_x_next = step_x_neg ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
    end
    if (move_y) begin
      cur_y_next = step_y_neg ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
    end
    in_frame = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1]
            && (CMP_BITS'($unsigned(cur_x)) < CMP_BITS'(frame.width))
            && (CMP_BITS'($unsigned(cur_y)) < CMP_BITS'(frame.height));
    at_end = (cur_x == goal_x) && (cur_y == goal_y);
  end

  // Loads and idle steps never need the result register, so they drain
  // even while a pixel waits to be taken.
  assign out_free  = !res_valid || res_ready;
  assign emits     = (item.op == OP_STEP) && active;
  assign item_take = item_valid && (!emits || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // A pixel stays until taken; a drawing step refills the register.
      res_valid <= (item_take && emits) || (res_valid && !res_ready);
      if (item_take) begin
        if (item.op == OP_LOAD) begin
          active <= 1'b1;
        end else if (active && at_end) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      if (item.op == OP_LOAD) begin
        cur_x       <= item.start_x;
        cur_y       <= item.start_y;
        goal_x      <= item.end_x;
        goal_y      <= item.end_y;
        delta_x     <= load_abs_dx;
        neg_delta_y <= load_ndy;
        error_term  <= load_err;
        step_x_neg  <= !(item.start_x < item.end_x);
        step_y_neg  <= !(item.start_y < item.end_y);
        line_color  <= item.color;
      end else if (active) begin
        res.pixel_x      <= cur_x;
        res.pixel_y      <= cur_y;
        res.pixel_color  <= line_color;
        res.write_enable <= in_frame;
        res.last         <= at_end;
        if (!at_end) begin
          cur_x      <= cur_x_next;
          cur_y      <= cur_y_next;
          error_term <= error_term_next;
        end
      end
    end
  end

endmodule
